/* rtl/bdm_pkg.sv */
`default_nettype none

package bdm_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 12;
  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 12'd1280;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             pad_pixel;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    d0;
    result_t    d1;
  } push_t;

endpackage

`default_nettype wire

/* rtl/bdm_if.sv */
`default_nettype none

interface bdm_in_if;
  logic                      valid;
  logic                      ready;
  logic [bdm_pkg::PIX_W-1:0] sample;
  logic                      frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface bdm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bdm_pkg::PIX_W-1:0] blue;
  logic [bdm_pkg::PIX_W-1:0] green;
  logic [bdm_pkg::PIX_W-1:0] red;
  logic                      pad_pixel;
  logic                      last;

  modport source (output valid, output blue, output green, output red,
                  output pad_pixel, output last, input ready);
  modport sink (input valid, input blue, input green, input red,
                input pad_pixel, input last, output ready);
endinterface

`default_nettype wire

/* rtl/bdm_line_buf.sv */
`default_nettype none

module bdm_line_buf #(
  parameter int DEPTH = bdm_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(bdm_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bdm_pkg::PIX_W-1:0] wdata,
  output logic      [bdm_pkg::PIX_W-1:0] rdata
);

  logic [bdm_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bdm_pkg::PIX_W-1:0] rdata_r;

  // Read-first: the old entry comes out while the new sample goes in.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/bdm_out_fifo.sv */
`default_nettype none

module bdm_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bdm_pkg::push_t push,
  output logic [1:0]          free,
  bdm_out_if.source           out_chan
);

  bdm_pkg::result_t ent_r [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             wr_ptr;
  logic             pop;
  bdm_pkg::result_t head;

  assign pop    = out_chan.valid && out_chan.ready;
  assign wr_ptr = rd_ptr_r ^ cnt_r[0];
  assign free   = 2'd2 - cnt_r + {1'b0, pop};

  always_comb begin
    cnt_nxt    = cnt_r + push.n - {1'b0, pop};
    rd_ptr_nxt = rd_ptr_r ^ pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      ent_r[wr_ptr] <= push.d0;
    end
    if (push.n == 2'd2) begin
      ent_r[~wr_ptr] <= push.d1;
    end
  end

  assign head               = ent_r[rd_ptr_r];
  assign out_chan.valid     = (cnt_r != 2'd0);
  assign out_chan.blue      = head.blue;
  assign out_chan.green     = head.green;
  assign out_chan.red       = head.red;
  assign out_chan.pad_pixel = head.pad_pixel;
  assign out_chan.last      = head.last;

endmodule

`default_nettype wire

/* rtl/bayer_rggb_to_bgr_demosaic_core.sv */
// Streaming RGGB Bayer demosaic. Raw samples enter one item per clock in raster order;
// one line store holds the row above, read and rewritten at the current column in the
// cycle the item is taken, and a window result is built from the registered item and leaves
// through a two-entry output queue. Every sample after the first row of a frame
// gives one pixel (none at column 0), and the last column of a row adds a zeroed pad
// pixel, so a row of line_width samples yields line_width results; the output port
// moves one result per clock while the sink is ready, and since the sample at column 0
// gives no result the queue absorbs the pad pixel, so with an always-ready sink the input
// never stalls and takes one item per clock. line_width is clamped to 2..MAX_WIDTH and
// must be written only while the block is idle.
`default_nettype none

module bayer_rggb_to_bgr_demosaic_core #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bdm_pkg::CFG_W-1:0] cfg_wdata,
  bdm_in_if.sink                         in_chan,
  bdm_out_if.source                      out_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > bdm_pkg::CFG_W) ? WW : bdm_pkg::CFG_W;
  localparam int PW = bdm_pkg::PIX_W;

  logic [bdm_pkg::CFG_W-1:0] line_width_r;

  logic [CW-1:0] col_r, col_nxt;
  logic          parity_r, parity_nxt;
  logic          past_first_r, past_first_nxt;
  logic [PW-1:0] left_cur_r;
  logic [PW-1:0] left_above_r;

  logic          s1_valid_r, s1_valid_nxt;
  logic [PW-1:0] s1_sample_r;
  logic [PW-1:0] s1_left_cur_r;
  logic          s1_emit_px_r;
  logic          s1_emit_pad_r;
  logic          s1_pt_r;
  logic          s1_pl_r;

  logic          accept;
  logic [CW-1:0] col_eff;
  logic          parity_eff;
  logic          past_first_eff;
  logic [XW-1:0] width_cfg;
  logic [XW-1:0] width_max;
  logic [XW-1:0] width_eff;
  logic          row_end;

  logic [PW-1:0]    above;
  logic [1:0]       s1_n;
  logic [1:0]       free;
  logic             s1_adv;
  bdm_pkg::push_t   push;
  bdm_pkg::result_t px_res;
  bdm_pkg::result_t pad_res;
  logic [PW-1:0]    win [4];
  logic [PW-1:0]    red_v;
  logic [PW-1:0]    blue_v;
  logic [PW:0]      gsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= bdm_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      line_width_r <= cfg_wdata;
    end
  end

  assign accept         = in_chan.valid && in_chan.ready;
  assign col_eff        = in_chan.frame_start ? '0 : col_r;
  assign parity_eff     = in_chan.frame_start ? 1'b0 : parity_r;
  assign past_first_eff = in_chan.frame_start ? 1'b0 : past_first_r;

  always_comb begin
    width_cfg = XW'(line_width_r);
    width_max = XW'(MAX_WIDTH);
    if (width_cfg < XW'(2)) begin
      width_eff = XW'(2);
    end else if (width_cfg > width_max) begin
      width_eff = width_max;
    end else begin
      width_eff = width_cfg;
    end
    row_end = (XW'(col_eff) + XW'(1)) >= width_eff;
  end

  always_comb begin
    col_nxt        = col_r;
    parity_nxt     = parity_r;
    past_first_nxt = past_first_r;
    if (accept) begin
      if (row_end) begin
        col_nxt        = '0;
        parity_nxt     = ~parity_eff;
        past_first_nxt = 1'b1;
      end else begin
        col_nxt        = col_eff + CW'(1);
        parity_nxt     = parity_eff;
        past_first_nxt = past_first_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      parity_r     <= 1'b0;
      past_first_r <= 1'b0;
      left_cur_r   <= '0;
    end else begin
      col_r        <= col_nxt;
      parity_r     <= parity_nxt;
      past_first_r <= past_first_nxt;
      if (accept) begin
        left_cur_r <= in_chan.sample;
      end
    end
  end

  bdm_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk   (clk),
    .en    (accept),
    .addr  (col_eff),
    .wdata (in_chan.sample),
    .rdata (above)
  );

  assign s1_n          = {1'b0, s1_emit_px_r} + {1'b0, s1_emit_pad_r};
  assign s1_adv        = s1_valid_r && (s1_n <= free);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      left_above_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        left_above_r <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r   <= in_chan.sample;
      s1_left_cur_r <= left_cur_r;
      s1_emit_px_r  <= past_first_eff && (col_eff != '0);
      s1_emit_pad_r <= past_first_eff && row_end;
      s1_pt_r       <= ~parity_eff;
      s1_pl_r       <= ~col_eff[0];
    end
  end

  always_comb begin
    logic yp;
    logic xp;
    win[0] = left_above_r;
    win[1] = above;
    win[2] = s1_left_cur_r;
    win[3] = s1_sample_r;
    red_v  = '0;
    blue_v = '0;
    gsum   = '0;
    for (int k = 0; k < 4; k++) begin
      yp = (k < 2) ? s1_pt_r : ~s1_pt_r;
      xp = ((k % 2) == 1) ? ~s1_pl_r : s1_pl_r;
      if (!yp && !xp) begin
        red_v = win[k];
      end else if (yp && xp) begin
        blue_v = win[k];
      end else begin
        gsum = gsum + {1'b0, win[k]};
      end
    end
  end

  always_comb begin
    px_res.blue      = blue_v;
    px_res.green     = gsum[PW:1];
    px_res.red       = red_v;
    px_res.pad_pixel = 1'b0;
    px_res.last      = ~s1_emit_pad_r;

    pad_res.blue      = '0;
    pad_res.green     = '0;
    pad_res.red       = '0;
    pad_res.pad_pixel = 1'b1;
    pad_res.last      = 1'b1;

    push.n  = s1_adv ? s1_n : 2'd0;
    push.d0 = s1_emit_px_r ? px_res : pad_res;
    push.d1 = pad_res;
  end

  bdm_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .free     (free),
    .out_chan (out_chan)
  );

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.n <= free)
    else $error("result push exceeds free output slots");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_end) |=> (col_r == '0) && past_first_r)
    else $error("column counter did not wrap at row end");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_sample_r) && $stable(above))
    else $error("stalled window item changed");

  a_pad_after_px: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_emit_pad_r) |-> s1_emit_px_r)
    else $error("pad pixel without window pixel");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int LINE_MAX = bdm_pkg::MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic                      is_cfg;
    logic [bdm_pkg::CFG_W-1:0] wval;
    logic [bdm_pkg::PIX_W-1:0] s;
    logic                      fs;
    logic                      typed;
    logic [1:0]                n;
    bdm_pkg::result_t          r0;
    bdm_pkg::result_t          r1;
  } plan_row_t;

  localparam bdm_pkg::result_t NO_PIX = '0;
  localparam bdm_pkg::result_t HI_LAST = '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1};
  localparam bdm_pkg::result_t HI_MID = '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0};
  localparam bdm_pkg::result_t PAD_LAST = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1};

  localparam int PLAN_LEN = 29;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b1, 12'd4, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b1, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd1, HI_LAST, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd1, HI_LAST, NO_PIX},
    '{1'b0, 12'd0, 8'd255, 1'b0, 1'b1, 2'd2, HI_MID, PAD_LAST},
    '{1'b0, 12'd0, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd31, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd200, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd17, 1'b1, 1'b1, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd90, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b1, 12'd2, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd33, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd250, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd5, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b1, 12'd0, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd128, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd64, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b1, 12'd1, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd7, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b1, 12'd3, 8'd0, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd9, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX},
    '{1'b0, 12'd0, 8'd200, 1'b0, 1'b0, 2'd0, NO_PIX, NO_PIX}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bdm_pkg::CFG_W-1:0] cfg_wdata;
  logic sink_ready = 1'b0;

  bdm_in_if in_ch ();
  bdm_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  bayer_rggb_to_bgr_demosaic_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_ch),
    .out_chan  (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [bdm_pkg::CFG_W-1:0] width_reg = bdm_pkg::LINE_WIDTH_RESET;
  logic [bdm_pkg::PIX_W-1:0] line_mem [LINE_MAX];
  logic [bdm_pkg::PIX_W-1:0] left_cur = '0;
  logic [bdm_pkg::PIX_W-1:0] left_up = '0;
  int unsigned col_next = 0;
  int unsigned rows_done = 0;
  int unsigned filled = 0;
  int unsigned frame_len_rows = 3;
  bit odd_row = 1'b0;
  bit row0_done = 1'b0;
  bit need_fs = 1'b0;
  bit quiet = 1'b0;
  bdm_pkg::result_t pending_pixels [$];
  int mismatch_count = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  function automatic int unsigned eff_width(input logic [bdm_pkg::CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  // Consumes one raw sample and returns the pixels it completes, oldest first.
  function automatic int demosaic_step(input logic [bdm_pkg::PIX_W-1:0] s, input logic fs,
                                       output bdm_pkg::result_t px0,
                                       output bdm_pkg::result_t px1);
    int unsigned w;
    int unsigned c;
    int n;
    logic [bdm_pkg::PIX_W-1:0] up;
    logic [bdm_pkg::PIX_W-1:0] win [4];
    logic [bdm_pkg::PIX_W-1:0] red;
    logic [bdm_pkg::PIX_W-1:0] blue;
    logic [bdm_pkg::PIX_W:0] gsum;
    bit pt;
    bit pl;
    bit yp;
    bit xp;
    bdm_pkg::result_t px [2];
    n = 0;
    px[0] = '0;
    px[1] = '0;
    up = '0;
    red = '0;
    blue = '0;
    gsum = '0;
    if (fs) begin
      col_next = 0;
      odd_row = 1'b0;
      row0_done = 1'b0;
      rows_done = 0;
      need_fs = 1'b0;
    end
    w = eff_width(width_reg);
    c = col_next;
    if (c < LINE_MAX) begin
      up = line_mem[c];
      line_mem[c] = s;
      if (c + 1 > filled) filled = c + 1;
    end
    if (row0_done && c >= 1) begin
      win[0] = left_up;
      win[1] = up;
      win[2] = left_cur;
      win[3] = s;
      pt = !odd_row;
      pl = ((c - 1) & 1) != 0;
      for (int k = 0; k < 4; k++) begin
        yp = (k < 2) ? pt : !pt;
        xp = (k % 2 == 1) ? !pl : pl;
        if (!yp && !xp) red = win[k];
        else if (yp && xp) blue = win[k];
        else gsum = gsum + win[k];
      end
      px[n] = '{blue, gsum[bdm_pkg::PIX_W:1], red, 1'b0, 1'b0};
      n++;
    end
    if (c + 1 >= w) begin
      if (row0_done) begin
        px[n] = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
        n++;
      end
      col_next = 0;
      odd_row = !odd_row;
      row0_done = 1'b1;
      rows_done++;
    end else begin
      col_next = c + 1;
    end
    left_cur = s;
    left_up = up;
    if (n > 0) px[n-1].last = 1'b1;
    px0 = px[0];
    px1 = px[1];
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_channel(input string name, input logic [bdm_pkg::PIX_W-1:0] got,
                                 input logic [bdm_pkg::PIX_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic push_sample(input logic [bdm_pkg::PIX_W-1:0] s, input logic fs,
                             input logic typed, input logic [1:0] tn,
                             input bdm_pkg::result_t t0, input bdm_pkg::result_t t1);
    bdm_pkg::result_t p0;
    bdm_pkg::result_t p1;
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = demosaic_step(s, fs, p0, p1);
    if (typed) begin
      n = tn;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_pixels.push_back(p0);
    if (n > 1) pending_pixels.push_back(p1);
  endtask

  // The block must be idle, including a sample that completes no pixel, before a write.
  task automatic set_line_width(input logic [bdm_pkg::CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = v;
    if (eff_width(v) > filled) need_fs = 1'b1;
  endtask

  task automatic stream_items(input int unsigned count, input bit noisy);
    logic [bdm_pkg::PIX_W-1:0] s;
    logic fs;
    repeat (count) begin
      fs = need_fs || (col_next == 0 && rows_done >= frame_len_rows) ||
           (noisy && $urandom_range(0, 149) == 0);
      if (fs) frame_len_rows = $urandom_range(3, 6);
      if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else s = 8'($urandom_range(0, 255));
      push_sample(s, fs, 1'b0, 2'd0, NO_PIX, NO_PIX);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) hold_left <= $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    bdm_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel arrived with none expected");
      end else begin
        want = pending_pixels.pop_front();
        compare_channel("blue", out_ch.blue, want.blue);
        compare_channel("green", out_ch.green, want.green);
        compare_channel("red", out_ch.red, want.red);
        compare_channel("pad_pixel", 8'(out_ch.pad_pixel), 8'(want.pad_pixel));
        compare_channel("last", 8'(out_ch.last), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    int random_items;
    int phase;
    int unsigned pick;
    int unsigned len;
    logic [bdm_pkg::CFG_W-1:0] wv;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.frame_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) set_line_width(PLAN[i].wval);
      else push_sample(PLAN[i].s, PLAN[i].fs, PLAN[i].typed, PLAN[i].n, PLAN[i].r0, PLAN[i].r1);
    end

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet = (random_items > RANDOM_ITEMS * 9 / 10) || ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // An out-of-range width acts as the maximum, so no row ends in this stretch.
        set_line_width(12'hFFF);
        stream_items(200, 1'b0);
        random_items += 200;
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) wv = bdm_pkg::CFG_W'($urandom_range(0, 1));
      else if (pick == 1) wv = 12'd2;
      else if (pick == 2) wv = bdm_pkg::CFG_W'($urandom_range(LINE_MAX + 1, 4095));
      else if (pick < 5) wv = bdm_pkg::CFG_W'($urandom_range(2, 64));
      else wv = bdm_pkg::CFG_W'($urandom_range(2, 24));
      set_line_width(wv);
      len = $urandom_range(10, 90);
      stream_items(len, 1'b1);
      random_items += len;
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
